// ----- rtl/modular_inverse_left_shift_macros.svh -----
// Assertion helpers for the top-level RTL file.
`ifndef MODULAR_INVERSE_LEFT_SHIFT_MACROS_SVH
`define MODULAR_INVERSE_LEFT_SHIFT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define MIL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define MIL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mil_pkg.sv -----
`timescale 1ns / 1ps

package mil_pkg;

    // operand / modulus bits actually used
    localparam int WIDTH    = 32;
    // port field width
    localparam int IO_W     = 32;
    // working values and coefficients are 64-bit two's complement
    localparam int DW       = 64;
    localparam int ITER_CAP = 8 * WIDTH + 8;
    // shift counts reach at most ITER_CAP + WIDTH + 1
    localparam int CNT_W    = $clog2(ITER_CAP + WIDTH + 2);
    localparam int LEN_W    = $clog2(WIDTH + 1);
    localparam int IDX_W    = $clog2(WIDTH);
    localparam int MIN_MOD  = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INIT,
        ST_TEST,
        ST_ADDW,
        ST_ADDC,
        ST_FIX1,
        ST_FIX2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] m;
        logic [WIDTH-1:0] a;
    } t_scan_ctl;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] mu;
        logic [LEN_W-1:0] mv;
    } t_scan_stat;

endpackage

// ----- rtl/mil_addsub.sv -----
`timescale 1ns / 1ps

// Shared 64-bit adder / subtractor: o_sum = i_x + i_y or i_x - i_y, wrapping.
module mil_addsub (
    input  logic [mil_pkg::DW-1:0] i_x,
    input  logic [mil_pkg::DW-1:0] i_y,
    input  logic                   i_sub,
    output logic [mil_pkg::DW-1:0] o_sum
);
    import mil_pkg::*;

    logic [DW-1:0] y_eff;

    assign y_eff = i_sub ? ~i_y : i_y;
    assign o_sum = i_x + y_eff + DW'(i_sub);

endmodule

// ----- rtl/mil_msb_scan.sv -----
`timescale 1ns / 1ps

// Bit-length of modulus and operand, one bit position per cycle.
module mil_msb_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mil_pkg::t_scan_ctl  i_ctl,
    output mil_pkg::t_scan_stat o_stat
);
    import mil_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [WIDTH-1:0] r_msh, n_msh;
    logic [WIDTH-1:0] r_ash, n_ash;
    logic [LEN_W-1:0] r_mu, n_mu;
    logic [LEN_W-1:0] r_mv, n_mv;
    logic [LEN_W-1:0] pos;

    assign pos = LEN_W'(r_idx) + LEN_W'(1);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_idx  = r_idx;
        n_msh  = r_msh;
        n_ash  = r_ash;
        n_mu   = r_mu;
        n_mv   = r_mv;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_msh  = i_ctl.m;
            n_ash  = i_ctl.a;
            n_mu   = '0;
            n_mv   = '0;
        end else if (r_busy) begin
            if (r_msh[0]) begin
                n_mu = pos;
            end
            if (r_ash[0]) begin
                n_mv = pos;
            end
            n_msh = r_msh >> 1;
            n_ash = r_ash >> 1;
            if (r_idx == IDX_W'(WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_msh <= n_msh;
        r_ash <= n_ash;
        r_mu  <= n_mu;
        r_mv  <= n_mv;
    end

    assign o_stat.done = r_done;
    assign o_stat.mu   = r_mu;
    assign o_stat.mv   = r_mv;

endmodule

// ----- rtl/modular_inverse_left_shift.sv -----
`timescale 1ns / 1ps
// Channel   | Dir | Signals                          | Payload
// ----------+-----+----------------------------------+---------------------------------
// s_axis    | in  | tvalid / tready / tdata[31:0]    | operand
// m_axis    | out | tvalid / tready / tdata / tuser  | tdata: inverse; tuser: no_inverse
// cfg       | in  | i_cfg_valid / o_cfg_ready / data | modulus (reset 3)
//
// Per request: accept, bit-length scan, setup (INIT), loop, sign fix (FIX1, FIX2), out.
// Loop: a doubling step is done within TEST; an add/subtract step passes TEST, then the
// working value (ADDW) and the coefficient (ADDC), all through one 64-bit adder.
// Rejected operands (zero, not below modulus, modulus below 3) go straight to output.
// Reset (i_rst_n low, synchronous) empties the result register and sets modulus to 3.
// s_axis_tready is high only while idle; a finished result waits in the output register
// while m_axis_tready is low, and the next request is taken once it has been loaded.
`include "modular_inverse_left_shift_macros.svh"

module modular_inverse_left_shift (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config write: modulus
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [mil_pkg::IO_W-1:0] i_cfg_data,
    // request: [31:0] operand
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [mil_pkg::IO_W-1:0] s_axis_tdata,
    // result: tdata [31:0] inverse; tuser [0] no_inverse
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [mil_pkg::IO_W-1:0] m_axis_tdata,
    output logic [0:0]               m_axis_tuser
);
    import mil_pkg::*;

    localparam logic [DW-1:0] ONES = '1;

    t_state r_state, n_state;

    logic [IO_W-1:0]  r_mod, n_mod;
    logic [WIDTH-1:0] r_a, n_a;
    logic [WIDTH-1:0] r_m, n_m;

    // working values, coefficients, powers 2^c and -2^c, mask of bits >= msb(m)
    logic [DW-1:0]    r_u, n_u;
    logic [DW-1:0]    r_v, n_v;
    logic [DW-1:0]    r_r, n_r;
    logic [DW-1:0]    r_s, n_s;
    logic [DW-1:0]    r_pu, n_pu;
    logic [DW-1:0]    r_npu, n_npu;
    logic [DW-1:0]    r_pv, n_pv;
    logic [DW-1:0]    r_npv, n_npv;
    logic [DW-1:0]    r_hm, n_hm;
    logic [CNT_W-1:0] r_cu, n_cu;
    logic [CNT_W-1:0] r_cv, n_cv;
    logic [CNT_W-1:0] r_it, n_it;
    logic             r_sub, n_sub;
    logic             r_tgt_u, n_tgt_u;
    logic             r_uneg, n_uneg;
    logic             r_fail, n_fail;

    logic             r_ovalid, n_ovalid;
    logic [IO_W-1:0]  r_odata, n_odata;
    logic             r_ofail, n_ofail;

    t_scan_ctl        scan_ctl;
    t_scan_stat       scan_stat;

    logic [DW-1:0]    add_x, add_y, add_sum;
    logic             add_sub;

    logic             in_acc, reject;
    logic [WIDTH-1:0] in_a;
    logic             hit_u, hit_v, small_u, small_v;
    logic [LEN_W-1:0] d, dp1, dm1;
    logic [DW-1:0]    m_ext;

    mil_msb_scan u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (scan_ctl),
        .o_stat (scan_stat)
    );

    mil_addsub u_add (
        .i_x  (add_x),
        .i_y  (add_y),
        .i_sub(add_sub),
        .o_sum(add_sum)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ofail;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_a   = s_axis_tdata[WIDTH-1:0];
    assign reject = (in_a == '0) || (r_mod[WIDTH-1:0] < WIDTH'(MIN_MOD))
                    || (in_a >= r_mod[WIDTH-1:0]);

    assign scan_ctl.start = in_acc && !reject;
    assign scan_ctl.m     = r_mod[WIDTH-1:0];
    assign scan_ctl.a     = in_a;

    assign m_ext = DW'(r_m);

    // |x| == 2^c: compare against 2^c or -2^c by sign
    assign hit_u = r_u[DW-1] ? (r_u == r_npu) : (r_u == r_pu);
    assign hit_v = r_v[DW-1] ? (r_v == r_npv) : (r_v == r_pv);
    // |x| < 2^msb(m): high bits all clear, or all set with some low bit set
    assign small_u = r_u[DW-1] ? (((r_u & r_hm) == r_hm) && ((r_u & ~r_hm) != '0))
                               : ((r_u & r_hm) == '0);
    assign small_v = r_v[DW-1] ? (((r_v & r_hm) == r_hm) && ((r_v & ~r_hm) != '0))
                               : ((r_v & r_hm) == '0);

    assign d   = scan_stat.mu - scan_stat.mv;
    assign dp1 = d + LEN_W'(1);
    assign dm1 = d - LEN_W'(1);

    // operand routing for the shared adder
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            ST_ADDW: begin
                add_x   = r_tgt_u ? r_u : r_v;
                add_y   = r_tgt_u ? r_v : r_u;
                add_sub = r_sub;
            end
            ST_ADDC: begin
                add_x   = r_tgt_u ? r_r : r_s;
                add_y   = r_tgt_u ? r_s : r_r;
                add_sub = r_sub;
            end
            ST_FIX1: begin
                // -r when r negative, m - r otherwise
                add_x   = r_r[DW-1] ? '0 : m_ext;
                add_y   = r_r;
                add_sub = 1'b1;
            end
            ST_FIX2: begin
                add_x   = m_ext;
                add_y   = r_r;
                add_sub = 1'b0;
            end
            default: begin
                add_x   = '0;
                add_y   = '0;
                add_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_mod    = r_mod;
        n_a      = r_a;
        n_m      = r_m;
        n_u      = r_u;
        n_v      = r_v;
        n_r      = r_r;
        n_s      = r_s;
        n_pu     = r_pu;
        n_npu    = r_npu;
        n_pv     = r_pv;
        n_npv    = r_npv;
        n_hm     = r_hm;
        n_cu     = r_cu;
        n_cv     = r_cv;
        n_it     = r_it;
        n_sub    = r_sub;
        n_tgt_u  = r_tgt_u;
        n_uneg   = r_uneg;
        n_fail   = r_fail;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_ofail  = r_ofail;

        if (i_cfg_valid && o_cfg_ready) begin
            n_mod = i_cfg_data;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_a    = in_a;
                    n_m    = r_mod[WIDTH-1:0];
                    n_fail = reject;
                    n_state = reject ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_stat.done) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                n_r  = '0;
                n_it = '0;
                n_hm = ONES << scan_stat.mu;
                if (scan_stat.mu > scan_stat.mv) begin
                    // shift m by 2 and a by d + 1: msb of a lands one below msb of m
                    n_u   = m_ext << 2;
                    n_cu  = CNT_W'(2);
                    n_pu  = DW'(4);
                    n_npu = ONES << 2;
                    n_v   = DW'(r_a) << dp1;
                    n_cv  = CNT_W'(dp1);
                    n_pv  = DW'(1) << dp1;
                    n_npv = ONES << dp1;
                    n_s   = DW'(1) << dm1;
                end else begin
                    n_u   = m_ext;
                    n_cu  = '0;
                    n_pu  = DW'(1);
                    n_npu = ONES;
                    n_v   = DW'(r_a);
                    n_cv  = '0;
                    n_pv  = DW'(1);
                    n_npv = ONES;
                    n_s   = DW'(1);
                end
                n_state = ST_TEST;
            end
            ST_TEST: begin
                if (hit_u || hit_v) begin
                    // v side wins when both hit
                    n_r     = hit_v ? r_s : r_r;
                    n_uneg  = hit_v ? r_v[DW-1] : r_u[DW-1];
                    n_state = ST_FIX1;
                end else if (r_it >= CNT_W'(ITER_CAP)) begin
                    n_fail  = 1'b1;
                    n_state = ST_OUT;
                end else if (small_u) begin
                    n_u   = r_u << 1;
                    if (r_cu >= r_cv) begin
                        n_r = r_r << 1;
                    end else begin
                        n_s = {r_s[DW-1], r_s[DW-1:1]};
                    end
                    n_cu  = r_cu + CNT_W'(1);
                    n_pu  = r_pu << 1;
                    n_npu = r_npu << 1;
                    n_it  = r_it + CNT_W'(1);
                    if (r_u[DW-2:0] == '0) begin
                        n_fail  = 1'b1;
                        n_state = ST_OUT;
                    end
                end else if (small_v) begin
                    n_v   = r_v << 1;
                    if (r_cv >= r_cu) begin
                        n_s = r_s << 1;
                    end else begin
                        n_r = {r_r[DW-1], r_r[DW-1:1]};
                    end
                    n_cv  = r_cv + CNT_W'(1);
                    n_pv  = r_pv << 1;
                    n_npv = r_npv << 1;
                    n_it  = r_it + CNT_W'(1);
                    if (r_v[DW-2:0] == '0) begin
                        n_fail  = 1'b1;
                        n_state = ST_OUT;
                    end
                end else begin
                    n_sub   = (r_u[DW-1] == r_v[DW-1]);
                    n_tgt_u = (r_cu <= r_cv);
                    n_it    = r_it + CNT_W'(1);
                    n_state = ST_ADDW;
                end
            end
            ST_ADDW: begin
                if (r_tgt_u) begin
                    n_u = add_sum;
                end else begin
                    n_v = add_sum;
                end
                n_state = ST_ADDC;
            end
            ST_ADDC: begin
                if (r_tgt_u) begin
                    n_r = add_sum;
                end else begin
                    n_s = add_sum;
                end
                if ((r_u == '0) || (r_v == '0)) begin
                    n_fail  = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_TEST;
                end
            end
            ST_FIX1: begin
                if (r_uneg) begin
                    n_r = add_sum;
                end
                n_state = ST_FIX2;
            end
            ST_FIX2: begin
                if (r_r[DW-1]) begin
                    n_r = add_sum;
                end
                n_fail  = 1'b0;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // wait for the result register to be free
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_fail ? '0 : r_r[IO_W-1:0];
                    n_ofail  = r_fail;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_mod    <= IO_W'(MIN_MOD);
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_mod    <= n_mod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_m     <= n_m;
        r_u     <= n_u;
        r_v     <= n_v;
        r_r     <= n_r;
        r_s     <= n_s;
        r_pu    <= n_pu;
        r_npu   <= n_npu;
        r_pv    <= n_pv;
        r_npv   <= n_npv;
        r_hm    <= n_hm;
        r_cu    <= n_cu;
        r_cv    <= n_cv;
        r_it    <= n_it;
        r_sub   <= n_sub;
        r_tgt_u <= n_tgt_u;
        r_uneg  <= n_uneg;
        r_fail  <= n_fail;
        r_odata <= n_odata;
        r_ofail <= n_ofail;
    end

    `MIL_ASSERT_NOW(a_fail_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "no_inverse with nonzero data")
    `MIL_ASSERT_NOW(a_work_nonzero, r_state == ST_TEST, (r_u != '0) && (r_v != '0), "working value zero in loop")
    `MIL_ASSERT_NOW(a_iter_bound, r_state == ST_TEST, r_it <= CNT_W'(ITER_CAP), "iteration count past cap")
    `MIL_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, r_state != ST_IDLE, "request accepted but block idle")

endmodule

// ----- tb/sv/modular_inverse_left_shift_checker.sv -----
`timescale 1ns / 1ps

module modular_inverse_left_shift_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [mil_pkg::IO_W-1:0] i_cfg_data,
    input  logic                     i_req_valid,
    input  logic                     i_req_ready,
    input  logic [mil_pkg::IO_W-1:0] i_req_data,
    input  logic                     i_res_valid,
    input  logic                     i_res_ready,
    input  logic [mil_pkg::IO_W-1:0] i_res_data,
    input  logic [0:0]               i_res_user,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [mil_pkg::IO_W-1:0] inverse;
        logic                     no_inverse;
    } t_inv_result;

    logic [mil_pkg::IO_W-1:0] modulus_q;
    t_inv_result              inverse_due[$];

    function automatic logic [63:0] magnitude(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic logic [63:0] half_signed(input logic [63:0] x);
        return {x[63], x[63:1]};
    endfunction

    // Binary left-shift inversion on 64-bit two's complement working values.
    function automatic t_inv_result mod_inverse_of(input logic [mil_pkg::IO_W-1:0] opnd,
                                                   input logic [mil_pkg::IO_W-1:0] modv);
        t_inv_result res;
        logic [63:0] m, a, u, v, r, s, pu, pv, au, av, lim;
        int unsigned mu, mv, cu, cv, d, it, i;
        logic        ok, fin;
        res.inverse    = '0;
        res.no_inverse = 1'b1;
        m = {32'd0, modv};
        a = {32'd0, opnd};
        if (a == 0 || m < mil_pkg::MIN_MOD || a >= m)
            return res;
        mu = 0;
        mv = 0;
        for (i = 0; i < mil_pkg::WIDTH; i++) begin
            if (m[i]) mu = i + 1;
            if (a[i]) mv = i + 1;
        end
        lim = 64'd1 << mu;
        u   = m;
        v   = a;
        r   = 64'd0;
        s   = 64'd1;
        cu  = 0;
        cv  = 0;
        pu  = 64'd1;
        pv  = 64'd1;
        // when the operand is shorter than the modulus, shift so its msb lands one below u's
        if (mu > mv) begin
            d  = mu - mv;
            u  = m << 2;
            cu = 2;
            pu = 64'd4;
            cv = d + 1;
            pv = 64'd1 << cv;
            v  = a << cv;
            s  = 64'd1 << (d - 1);
        end
        au  = magnitude(u);
        av  = magnitude(v);
        ok  = 1'b1;
        fin = 1'b0;
        it  = 0;
        while (ok && !fin) begin
            if (au == pu || av == pv) begin
                fin = 1'b1;
            end else if (it >= mil_pkg::ITER_CAP) begin
                ok = 1'b0;
            end else begin
                if (au < lim) begin
                    u = u << 1;
                    if (cu >= cv) r = r << 1;
                    else          s = half_signed(s);
                    cu++;
                    pu = pu << 1;
                end else if (av < lim) begin
                    v = v << 1;
                    if (cv >= cu) s = s << 1;
                    else          r = half_signed(r);
                    cv++;
                    pv = pv << 1;
                end else if (u[63] == v[63]) begin
                    if (cu <= cv) begin
                        u = u - v;
                        r = r - s;
                    end else begin
                        v = v - u;
                        s = s - r;
                    end
                end else begin
                    if (cu <= cv) begin
                        u = u + v;
                        r = r + s;
                    end else begin
                        v = v + u;
                        s = s + r;
                    end
                end
                if (u == 0 || v == 0) begin
                    ok = 1'b0;
                end else begin
                    au = magnitude(u);
                    av = magnitude(v);
                end
                it++;
            end
        end
        if (!ok)
            return res;
        if (av == pv) begin
            r = s;
            u = v;
        end
        if (u[63])
            r = r[63] ? (64'd0 - r) : (m - r);
        if (r[63])
            r = m + r;
        res.inverse    = r[mil_pkg::IO_W-1:0];
        res.no_inverse = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_inv_result want;
        if (!i_rst_n) begin
            modulus_q = mil_pkg::IO_W'(mil_pkg::MIN_MOD);
            inverse_due.delete();
            o_fail_count = 0;
        end else begin
            // result first, so a request in the same cycle never matches itself
            if (i_res_valid && i_res_ready) begin
                if (inverse_due.size() == 0) begin
                    $display("%0t: unexpected result inverse %h no_inverse %b",
                             $time, i_res_data, i_res_user[0]);
                    o_fail_count++;
                end else begin
                    want = inverse_due.pop_front();
                    if (i_res_data !== want.inverse) begin
                        $display("%0t: inverse mismatch: expected %h, actual %h",
                                 $time, want.inverse, i_res_data);
                        o_fail_count++;
                    end
                    if (i_res_user[0] !== want.no_inverse) begin
                        $display("%0t: no_inverse mismatch: expected %b, actual %b",
                                 $time, want.no_inverse, i_res_user[0]);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                inverse_due.push_back(mod_inverse_of(i_req_data, modulus_q));
            if (i_cfg_valid && i_cfg_ready)
                modulus_q = i_cfg_data;
        end
        o_pending = inverse_due.size();
    end

endmodule

// ----- tb/sv/tb_modular_inverse_left_shift.sv -----
`timescale 1ns / 1ps

module tb_modular_inverse_left_shift;

    // cycles with no handshake on any channel before giving up; stalls on either
    // side add little to the time one request takes
    localparam int STALL_LIMIT    = 20000;
    localparam int ITEMS_PER_SET  = 95;
    localparam int NUM_SETS       = 16;
    localparam logic [31:0] BIG_PRIME = 32'd4294967291;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [mil_pkg::IO_W-1:0] i_cfg_data;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [mil_pkg::IO_W-1:0] s_axis_tdata;   // [31:0] operand
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [mil_pkg::IO_W-1:0] m_axis_tdata;   // [31:0] inverse
    logic [0:0]               m_axis_tuser;   // [0] no_inverse

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    int stall_cycles;

    modular_inverse_left_shift dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    modular_inverse_left_shift_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns period
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog: any accepted transfer restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                     (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("modular_inverse_left_shift verification failed");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [31:0] operand);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= operand;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // hold off the sender until every outstanding result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // modulus is only written with the block idle
    task automatic write_modulus(input logic [31:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly valid operands, with zeros, out-of-range values and short ones mixed in
    function automatic logic [31:0] pick_operand(input logic [31:0] modv);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            return 32'd0;
        else if (sel < 6)
            return modv;
        else if (sel < 10)
            return $urandom;
        else if (sel < 14)
            return ($urandom_range(0, 1) != 0) ? (modv - 32'd1) : 32'd1;
        else if (sel < 30)
            return $urandom >> $urandom_range(0, 31);
        else
            return 32'(64'd1 + ({32'd0, $urandom} % ({32'd0, modv} - 64'd1)));
    endfunction

    function automatic logic [31:0] pick_modulus(input int idx);
        logic [31:0] mv;
        case (idx)
            0:  return 32'd3;
            1:  return 32'd5;
            2:  return 32'd7;
            3:  return 32'd251;
            4:  return 32'd257;
            5:  return 32'd65521;
            6:  return 32'd65537;
            7:  return 32'd2147483647;
            8:  return BIG_PRIME;
            9:  return 32'hFFFF_FFFF;       // largest value, not prime
            10: return 32'd15;              // small composite
            11: return 32'd1000003;
            default: begin
                // random width, odd unless lifted by 5, usually composite
                mv = ($urandom >> $urandom_range(0, 28)) | 32'd1;
                if (mv < 32'd5)
                    mv = mv + 32'd5;
                return mv;
            end
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] modv;
        int          set_idx;
        int          k;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_idle_pct   = 17;
        rx_idle_pct   = 49;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: operand extremes against the largest 32-bit prime
        write_modulus(BIG_PRIME);
        send_request(32'd0);
        send_request(32'd1);
        send_request(32'd2);
        send_request(32'd3);
        send_request(BIG_PRIME - 32'd1);
        send_request(BIG_PRIME);
        send_request(BIG_PRIME + 32'd1);
        send_request(32'hFFFF_FFFF);
        send_request(32'h8000_0000);
        send_request(32'h7FFF_FFFF);
        send_request((BIG_PRIME - 32'd1) >> 1);
        send_request(32'h5555_5555);
        send_request(32'hAAAA_AAAA);
        // smallest legal modulus
        write_modulus(32'd3);
        send_request(32'd1);
        send_request(32'd2);
        send_request(32'd3);
        send_request(32'd0);
        // composite modulus: working values can cancel to zero
        write_modulus(32'd15);
        send_request(32'd3);
        send_request(32'd5);
        send_request(32'd7);
        send_request(32'd14);
        // modulus below three is rejected
        write_modulus(32'd2);
        send_request(32'd1);
        write_modulus(32'd0);
        send_request(32'd1);

        // random sets, idling pattern changes by thirds
        for (set_idx = 0; set_idx < NUM_SETS; set_idx++) begin
            if (set_idx == 6) begin
                tx_idle_pct = 49;
                rx_idle_pct = 17;
            end else if (set_idx == 11) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            modv = pick_modulus(set_idx);
            write_modulus(modv);
            for (k = 0; k < ITEMS_PER_SET; k++) begin
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                send_request(pick_operand(modv));
            end
        end

        drain_results();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("modular_inverse_left_shift verification clean");
        else
            $display("modular_inverse_left_shift verification failed");
        $finish;
    end

endmodule
